// File: rtl/lrvs_pkg.sv
// ----------------------------------------------------------------------------
// lrvs_pkg
// Shared field widths, operation, status and register codes, and the rail
// storage write bundle for the locked rail voltage sequencer.
// ----------------------------------------------------------------------------
package lrvs_pkg;

  // port field widths
  localparam int VOLT_W      = 24;
  localparam int SPREAD_W    = 24;
  localparam int COUNT_W     = 3;
  localparam int OP_W        = 2;
  localparam int IDX_W       = 2;
  localparam int STATUS_W    = 3;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 24;

  // operation codes
  localparam logic [OP_W-1:0] OP_PRESET  = 2'd0;
  localparam logic [OP_W-1:0] OP_REQUEST = 2'd1;
  localparam logic [OP_W-1:0] OP_ACK     = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_MOVE  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DONE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BUSY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABORT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_STRAY = 3'd4;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SPREAD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAIL_COUNT = 1'd1;

  // configuration reset values
  localparam logic [SPREAD_W-1:0] SPREAD_RESET = 24'd100000;
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = 3'd2;

  // write enables into the rail storage
  typedef struct packed {
    logic des_we;
    logic act_we;
    logic tgt_we;
  } rail_wr_t;

endpackage

// File: rtl/lrvs_unit.sv
// ----------------------------------------------------------------------------
// lrvs_unit
// Shared add and compare unit: forms a + b and compares the sum against c.
// ----------------------------------------------------------------------------
module lrvs_unit #(
  parameter int SW = 26
) (
  input  logic signed [SW-1:0] a,
  input  logic signed [SW-1:0] b,
  input  logic signed [SW-1:0] c,
  output logic signed [SW-1:0] sum,
  output logic                 lt,
  output logic                 eq
);

  // offset add followed by signed compare
  always_comb begin
    sum = a + b;
    lt  = (sum < c);
    eq  = (sum == c);
  end

endmodule

// File: rtl/lrvs_rails.sv
// ----------------------------------------------------------------------------
// lrvs_rails
// Per-rail desired, actual and target voltage storage with one shared read
// address and one shared write address.
// ----------------------------------------------------------------------------
module lrvs_rails #(
  parameter int RAILS     = 4,
  parameter int VOLT_BITS = 24,
  parameter int IW        = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lrvs_pkg::rail_wr_t    wr,
  input  logic [IW-1:0]         waddr,
  input  logic [VOLT_BITS-1:0]  des_wdata,
  input  logic [VOLT_BITS-1:0]  act_wdata,
  input  logic [VOLT_BITS-1:0]  tgt_wdata,
  input  logic [IW-1:0]         raddr,
  output logic [VOLT_BITS-1:0]  des_rd,
  output logic [VOLT_BITS-1:0]  act_rd,
  output logic [VOLT_BITS-1:0]  tgt_rd
);

  logic [VOLT_BITS-1:0] desired [RAILS];
  logic [VOLT_BITS-1:0] actual  [RAILS];
  logic [VOLT_BITS-1:0] target  [RAILS];

  // desired and actual have no reset and hold whatever was last written
  always_ff @(posedge clk) begin
    if (wr.des_we) begin
      desired[waddr] <= des_wdata;
    end
    if (wr.act_we) begin
      actual[waddr] <= act_wdata;
    end
  end

  // targets clear on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < RAILS; k++) begin
        target[k] <= '0;
      end
    end else if (wr.tgt_we) begin
      target[waddr] <= tgt_wdata;
    end
  end

  // single read port
  assign des_rd = desired[raddr];
  assign act_rd = actual[raddr];
  assign tgt_rd = target[raddr];

endmodule

// File: rtl/locked_rail_voltage_sequencer.sv
// ----------------------------------------------------------------------------
// locked_rail_voltage_sequencer
// Keeps up to RAILS supply rails within max_spread of each other and issues
// one rail move at a time toward each rail's target.
// ----------------------------------------------------------------------------
// One request is handled at a time and every request gives one result. All
// arithmetic goes through a single add and compare unit stepped by the
// sequencer below, so the work per request grows with the rails in use.
// Preset, refused, aborted and stray requests go from accept straight to
// readback and result. Picking the next move scans the rails: a rail already at
// its target is skipped, otherwise two passes over the other rails find their
// highest and lowest actual voltage, then come up to four clamp and compare
// steps. An acknowledge runs this scan over all rails in use; a voltage request
// first forms the targets from the trend, the highest and lowest desired
// voltage and the floor. While a result waits on the output the next
// request can already be accepted and worked on. Rail voltages read before a
// preset has written them are undefined.
// ----------------------------------------------------------------------------
module locked_rail_voltage_sequencer #(
  parameter int RAILS     = 4,
  parameter int VOLT_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lrvs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lrvs_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input requests
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lrvs_pkg::OP_W-1:0]           operation,
  input  logic [lrvs_pkg::IDX_W-1:0]          rail_index,
  input  logic [lrvs_pkg::VOLT_W-1:0]         voltage,
  input  logic                                downstream_error,
  // results
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lrvs_pkg::STATUS_W-1:0]       status,
  output logic [lrvs_pkg::IDX_W-1:0]          move_rail,
  output logic [lrvs_pkg::VOLT_W-1:0]         move_voltage,
  output logic [lrvs_pkg::VOLT_W-1:0]         rail_voltage
);

  localparam int IW    = (RAILS > 1) ? $clog2(RAILS) : 1;
  localparam int CMPW  = $clog2(RAILS + 1) + 3;
  localparam int WIDE  = (VOLT_BITS > lrvs_pkg::SPREAD_W) ? VOLT_BITS : lrvs_pkg::SPREAD_W;
  localparam int SW    = WIDE + 2;
  localparam int VW    = lrvs_pkg::VOLT_W;
  localparam int XW    = lrvs_pkg::IDX_W;
  localparam logic [VOLT_BITS-1:0] VMAX = {VOLT_BITS{1'b1}};

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_REQ   = 4'd1;
  localparam logic [3:0] S_HI    = 4'd2;
  localparam logic [3:0] S_LO    = 4'd3;
  localparam logic [3:0] S_FLOOR = 4'd4;
  localparam logic [3:0] S_TGT   = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_OHI   = 4'd7;
  localparam logic [3:0] S_OLO   = 4'd8;
  localparam logic [3:0] S_CLMPH = 4'd9;
  localparam logic [3:0] S_CLMPL = 4'd10;
  localparam logic [3:0] S_CMPA  = 4'd11;
  localparam logic [3:0] S_CMPB  = 4'd12;
  localparam logic [3:0] S_RDV   = 4'd13;

  function automatic logic signed [SW-1:0] ext_v(input logic [VOLT_BITS-1:0] x);
    return $signed({{(SW-VOLT_BITS){1'b0}}, x});
  endfunction

  function automatic logic signed [SW-1:0] ext_s(input logic [lrvs_pkg::SPREAD_W-1:0] x);
    return $signed({{(SW-lrvs_pkg::SPREAD_W){1'b0}}, x});
  endfunction

  // configuration
  logic [lrvs_pkg::SPREAD_W-1:0] max_spread;
  logic [lrvs_pkg::COUNT_W-1:0]  rail_count;

  // control state
  logic [3:0]            state;
  logic                  busy;
  logic                  rising;
  logic [IW-1:0]         pending_rail;
  logic [VOLT_BITS-1:0]  pending_voltage;
  logic [lrvs_pkg::STATUS_W-1:0] status_r;
  logic                  found;
  logic [IW-1:0]         best_i;
  logic [VOLT_BITS-1:0]  best;
  logic [IW-1:0]         cur_i;
  logic [IW-1:0]         scan;

  // latched request and working values
  logic [IW-1:0]         idx_l;
  logic                  in_use_l;
  logic [VOLT_BITS-1:0]  volt_l;
  logic [VOLT_BITS-1:0]  hi;
  logic [VOLT_BITS-1:0]  lo;
  logic [VOLT_BITS-1:0]  floor_v;
  logic [VOLT_BITS-1:0]  cur_act;
  logic [VOLT_BITS-1:0]  cur_tgt;
  logic [VOLT_BITS-1:0]  ohi;
  logic [VOLT_BITS-1:0]  olo;
  logic [VOLT_BITS-1:0]  v;

  // rail storage interface
  lrvs_pkg::rail_wr_t    wr;
  logic [IW-1:0]         waddr;
  logic [IW-1:0]         raddr;
  logic [VOLT_BITS-1:0]  des_wdata;
  logic [VOLT_BITS-1:0]  act_wdata;
  logic [VOLT_BITS-1:0]  tgt_wdata;
  logic [VOLT_BITS-1:0]  des_rd;
  logic [VOLT_BITS-1:0]  act_rd;
  logic [VOLT_BITS-1:0]  tgt_rd;

  // shared unit interface
  logic signed [SW-1:0]  ua;
  logic signed [SW-1:0]  ub;
  logic signed [SW-1:0]  uc;
  logic signed [SW-1:0]  usum;
  logic                  ult;
  logic                  ueq;
  logic                  ugt;

  // derived control
  logic [CMPW-1:0]       rc_ext;
  logic [CMPW-1:0]       n_rails;
  logic [CMPW-1:0]       n_last;
  logic                  scan_last;
  logic                  i_last;
  logic                  accept;
  logic                  in_use;
  logic [IW-1:0]         idx_in;
  logic [VOLT_BITS-1:0]  volt_in;
  logic                  take;
  logic                  fnd_c;
  logic [IW-1:0]         bi_c;
  logic [VOLT_BITS-1:0]  bv_c;
  logic                  slot_free;
  logic [VOLT_BITS-1:0]  rd_v;

  // rails in use, clamped to the supported range
  always_comb begin
    rc_ext = CMPW'(rail_count);
    if (rc_ext < CMPW'(2)) begin
      n_rails = CMPW'(2);
    end else if (rc_ext > CMPW'(RAILS)) begin
      n_rails = CMPW'(RAILS);
    end else begin
      n_rails = rc_ext;
    end
    n_last = n_rails - CMPW'(1);
  end

  assign scan_last = (CMPW'(scan) == n_last);
  assign i_last    = (CMPW'(cur_i) == n_last);

  // input decode
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_use   = (CMPW'(rail_index) < n_rails);
  assign idx_in   = IW'(rail_index);
  assign volt_in  = VOLT_BITS'(voltage);
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_spread <= lrvs_pkg::SPREAD_RESET;
      rail_count <= lrvs_pkg::COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lrvs_pkg::CFG_MAX_SPREAD: max_spread <= lrvs_pkg::SPREAD_W'(cfg_data);
        lrvs_pkg::CFG_RAIL_COUNT: rail_count <= lrvs_pkg::COUNT_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // operand selection for the shared unit
  always_comb begin
    ua = '0;
    ub = '0;
    uc = '0;
    unique case (state)
      S_REQ: begin
        ua = ext_v(volt_l);
        uc = ext_v(des_rd);
      end
      S_HI: begin
        ua = ext_v(des_rd);
        uc = ext_v(hi);
      end
      S_LO: begin
        ua = ext_v(des_rd);
        uc = ext_v(lo);
      end
      S_FLOOR: begin
        ua = ext_v(hi);
        ub = -ext_s(max_spread);
        uc = ext_v(lo);
      end
      S_TGT: begin
        ua = ext_v(des_rd);
        uc = ext_v(floor_v);
      end
      S_CHK: begin
        ua = ext_v(act_rd);
        uc = ext_v(tgt_rd);
      end
      S_OHI: begin
        ua = ext_v(act_rd);
        uc = ext_v(ohi);
      end
      S_OLO: begin
        ua = ext_v(act_rd);
        uc = ext_v(olo);
      end
      S_CLMPH: begin
        ua = ext_v(ohi);
        ub = -ext_s(max_spread);
        uc = ext_v(cur_tgt);
      end
      S_CLMPL: begin
        ua = ext_v(olo);
        ub = ext_s(max_spread);
        uc = ext_v(v);
      end
      S_CMPA: begin
        ua = ext_v(v);
        uc = ext_v(cur_act);
      end
      S_CMPB: begin
        ua = ext_v(v);
        uc = ext_v(best);
      end
      default: ;
    endcase
  end

  lrvs_unit #(
    .SW (SW)
  ) u_unit (
    .a   (ua),
    .b   (ub),
    .c   (uc),
    .sum (usum),
    .lt  (ult),
    .eq  (ueq)
  );

  assign ugt = !ult && !ueq;

  // candidate selection: lowest when rising, highest when falling, first wins ties
  always_comb begin
    take  = (state == S_CMPB) && (!found || (rising && ult) || (!rising && ugt));
    fnd_c = found || take;
    bi_c  = take ? cur_i : best_i;
    bv_c  = take ? v : best;
  end

  // rail storage read address
  always_comb begin
    unique case (state)
      S_REQ, S_RDV: raddr = idx_l;
      S_CHK:        raddr = cur_i;
      default:      raddr = scan;
    endcase
  end

  // rail storage writes: preset and acknowledge at accept, desired and targets later
  always_comb begin
    wr        = '0;
    waddr     = scan;
    des_wdata = volt_l;
    act_wdata = volt_in;
    tgt_wdata = ult ? floor_v : des_rd;
    if (accept) begin
      waddr     = idx_in;
      des_wdata = volt_in;
      if (operation == lrvs_pkg::OP_PRESET && !busy && in_use) begin
        wr.des_we = 1'b1;
        wr.act_we = 1'b1;
      end else if (operation == lrvs_pkg::OP_ACK && busy && !downstream_error) begin
        waddr     = pending_rail;
        act_wdata = pending_voltage;
        wr.act_we = 1'b1;
      end
    end else if (state == S_REQ) begin
      waddr     = idx_l;
      wr.des_we = 1'b1;
    end else if (state == S_TGT) begin
      wr.tgt_we = 1'b1;
    end
  end

  lrvs_rails #(
    .RAILS     (RAILS),
    .VOLT_BITS (VOLT_BITS),
    .IW        (IW)
  ) u_rails (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .waddr     (waddr),
    .des_wdata (des_wdata),
    .act_wdata (act_wdata),
    .tgt_wdata (tgt_wdata),
    .raddr     (raddr),
    .des_rd    (des_rd),
    .act_rd    (act_rd),
    .tgt_rd    (tgt_rd)
  );

  assign rd_v = in_use_l ? act_rd : '0;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      busy            <= 1'b0;
      rising          <= 1'b0;
      pending_rail    <= '0;
      pending_voltage <= '0;
      found           <= 1'b0;
      out_valid       <= 1'b0;
      status_r        <= lrvs_pkg::ST_DONE;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            idx_l    <= idx_in;
            in_use_l <= in_use;
            volt_l   <= volt_in;
            state    <= S_RDV;
            status_r <= lrvs_pkg::ST_DONE;
            unique case (operation)
              lrvs_pkg::OP_PRESET: begin
                if (busy) begin
                  status_r <= lrvs_pkg::ST_BUSY;
                end
              end
              lrvs_pkg::OP_REQUEST: begin
                if (busy) begin
                  status_r <= lrvs_pkg::ST_BUSY;
                end else if (in_use) begin
                  state <= S_REQ;
                end
              end
              lrvs_pkg::OP_ACK: begin
                if (!busy) begin
                  status_r <= lrvs_pkg::ST_STRAY;
                end else if (downstream_error) begin
                  busy     <= 1'b0;
                  status_r <= lrvs_pkg::ST_ABORT;
                end else begin
                  cur_i <= '0;
                  found <= 1'b0;
                  state <= S_CHK;
                end
              end
              lrvs_pkg::OP_NONE: begin
                status_r <= lrvs_pkg::ST_STRAY;
              end
              default: ;
            endcase
          end
        end
        // trend against the old desired voltage
        S_REQ: begin
          rising <= ugt;
          scan   <= '0;
          hi     <= '0;
          state  <= S_HI;
        end
        // highest desired voltage
        S_HI: begin
          if (ugt) begin
            hi <= des_rd;
          end
          if (scan_last) begin
            scan  <= '0;
            lo    <= VMAX;
            state <= S_LO;
          end else begin
            scan <= scan + IW'(1);
          end
        end
        // lowest desired voltage
        S_LO: begin
          if (ult) begin
            lo <= des_rd;
          end
          if (scan_last) begin
            state <= S_FLOOR;
          end else begin
            scan <= scan + IW'(1);
          end
        end
        // floor: highest minus spread, not below the lowest
        S_FLOOR: begin
          floor_v <= ult ? lo : usum[VOLT_BITS-1:0];
          scan    <= '0;
          state   <= S_TGT;
        end
        // targets written through the storage port
        S_TGT: begin
          if (scan_last) begin
            cur_i <= '0;
            found <= 1'b0;
            state <= S_CHK;
          end else begin
            scan <= scan + IW'(1);
          end
        end
        // skip rails already on target
        S_CHK: begin
          cur_act <= act_rd;
          cur_tgt <= tgt_rd;
          if (ueq) begin
            if (i_last) begin
              busy  <= fnd_c;
              state <= S_RDV;
              if (fnd_c) begin
                pending_rail    <= bi_c;
                pending_voltage <= bv_c;
                status_r        <= lrvs_pkg::ST_MOVE;
              end else begin
                status_r <= lrvs_pkg::ST_DONE;
              end
            end else begin
              cur_i <= cur_i + IW'(1);
            end
          end else begin
            scan  <= '0;
            ohi   <= '0;
            state <= S_OHI;
          end
        end
        // highest actual voltage of the other rails
        S_OHI: begin
          if (scan != cur_i && ugt) begin
            ohi <= act_rd;
          end
          if (scan_last) begin
            scan  <= '0;
            olo   <= VMAX;
            state <= S_OLO;
          end else begin
            scan <= scan + IW'(1);
          end
        end
        // lowest actual voltage of the other rails
        S_OLO: begin
          if (scan != cur_i && ult) begin
            olo <= act_rd;
          end
          if (scan_last) begin
            state <= S_CLMPH;
          end else begin
            scan <= scan + IW'(1);
          end
        end
        // raise to the others' highest minus spread
        S_CLMPH: begin
          v     <= ult ? cur_tgt : usum[VOLT_BITS-1:0];
          state <= S_CLMPL;
        end
        // cap at the others' lowest plus spread
        S_CLMPL: begin
          if (ult) begin
            v <= usum[VOLT_BITS-1:0];
          end
          state <= S_CMPA;
        end
        // a rail that cannot move is no candidate
        S_CMPA: begin
          if (ueq) begin
            if (i_last) begin
              busy  <= fnd_c;
              state <= S_RDV;
              if (fnd_c) begin
                pending_rail    <= bi_c;
                pending_voltage <= bv_c;
                status_r        <= lrvs_pkg::ST_MOVE;
              end else begin
                status_r <= lrvs_pkg::ST_DONE;
              end
            end else begin
              cur_i <= cur_i + IW'(1);
              state <= S_CHK;
            end
          end else begin
            state <= S_CMPB;
          end
        end
        // compare against the best candidate so far
        S_CMPB: begin
          found  <= fnd_c;
          best_i <= bi_c;
          best   <= bv_c;
          if (i_last) begin
            busy  <= fnd_c;
            state <= S_RDV;
            if (fnd_c) begin
              pending_rail    <= bi_c;
              pending_voltage <= bv_c;
              status_r        <= lrvs_pkg::ST_MOVE;
            end else begin
              status_r <= lrvs_pkg::ST_DONE;
            end
          end else begin
            cur_i <= cur_i + IW'(1);
            state <= S_CHK;
          end
        end
        // read back the addressed rail and hand over the result
        S_RDV: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_RDV && slot_free) begin
      status       <= status_r;
      move_rail    <= (status_r == lrvs_pkg::ST_MOVE) ? XW'(pending_rail) : '0;
      move_voltage <= (status_r == lrvs_pkg::ST_MOVE) ? VW'(pending_voltage) : '0;
      rail_voltage <= VW'(rd_v);
    end
  end

`ifndef ASSERT_OFF
  // every accepted request leaves idle on the next cycle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("sequencer stayed idle after accepting a request");

  // a move result is only handed over while a sequence is running
  a_move_needs_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDV && status_r == lrvs_pkg::ST_MOVE) |-> busy)
    else $error("move reported without an active sequence");

  // a sequence starts only when the scan found a candidate
  a_busy_from_found: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(fnd_c))
    else $error("sequence started without a chosen move");

  // the desired voltage bounds are ordered before the floor is formed
  a_floor_bounds: assert property (@(posedge clk) disable iff (rst)
    state == S_FLOOR |-> lo <= hi)
    else $error("lowest desired voltage above highest");

  // results only appear from the readback state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_RDV)
    else $error("result raised outside readback");
`endif

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the locked rail voltage sequencer. Requests come from
// a backlog that the stimulus process fills. A clocked driver offers them with
// random gaps and a clocked monitor collects the replies. Each accepted request
// runs through a behavioral copy of the sequencer, and every reply is checked
// field by field against the oldest predicted reply. Stimulus is a short
// directed bring-up followed by five register settings of mostly well-formed
// move sequences, with noise, refusals and aborts mixed in.
// ----------------------------------------------------------------------------
module testbench;
  import lrvs_pkg::*;

  localparam int RAILS       = 4;
  localparam int STALL_LONG  = 400;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 100;
  localparam int MAX_REPORTS = 100;
  localparam int PHASES      = 5;
  localparam logic [VOLT_W-1:0] VOLT_MAX = '1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [VOLT_W-1:0] volt;
    logic              err;
  } rail_request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    mrail;
    logic [VOLT_W-1:0]   mvolt;
    logic [VOLT_W-1:0]   rvolt;
  } rail_reply_t;

  // block ports
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [OP_W-1:0]        operation = '0;
  logic [IDX_W-1:0]       rail_index = '0;
  logic [VOLT_W-1:0]      voltage = '0;
  logic                   downstream_error = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic [IDX_W-1:0]       move_rail;
  logic [VOLT_W-1:0]      move_voltage;
  logic [VOLT_W-1:0]      rail_voltage;

  // sequencer shadow state
  logic [VOLT_W-1:0]   desired_v [RAILS] = '{default: '0};
  logic [VOLT_W-1:0]   actual_v  [RAILS] = '{default: '0};
  logic [VOLT_W-1:0]   target_v  [RAILS] = '{default: '0};
  logic                rising = 1'b0;
  logic                seq_busy = 1'b0;
  logic [IDX_W-1:0]    move_idx = '0;
  logic [VOLT_W-1:0]   move_v = '0;
  logic [SPREAD_W-1:0] cfg_spread = SPREAD_RESET;
  logic [COUNT_W-1:0]  cfg_count = COUNT_RESET;

  // bench bookkeeping
  rail_request_t request_backlog [$];
  rail_reply_t   predicted_replies [$];
  rail_request_t next_rq;
  rail_reply_t   want_reply;
  bit            offering = 1'b0;
  bit            steady_flow = 1'b0;
  bit            stall_request = 1'b0;
  int unsigned   send_gap = 0;
  int unsigned   ready_gap = 0;
  int unsigned   hold_left = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   errors = 0;
  int unsigned   accepted = 0;
  int unsigned   real_requests = 0;
  int unsigned   cfg_writes = 0;
  int unsigned   status_seen [8] = '{default: 0};
  longint        base_v = 0;

  locked_rail_voltage_sequencer dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .rail_index       (rail_index),
    .voltage          (voltage),
    .downstream_error (downstream_error),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .move_rail        (move_rail),
    .move_voltage     (move_voltage),
    .rail_voltage     (rail_voltage)
  );

  // clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // rail count clamped to the supported range
  function automatic int unsigned rails_active();
    if (cfg_count < 2) return 2;
    if (cfg_count > RAILS) return RAILS;
    return cfg_count;
  endfunction

  // pick the next legal move toward the targets, lowest voltage when rising
  function automatic bit next_move();
    int unsigned n;
    int unsigned best_i;
    bit          found;
    longint      best_v, act, lo, hi, v, sp;
    n = rails_active();
    found = 1'b0;
    best_v = 0;
    best_i = 0;
    sp = cfg_spread;
    for (int i = 0; i < n; i++) begin
      if (actual_v[i] == target_v[i]) continue;
      act = actual_v[i];
      lo = VOLT_MAX;
      hi = 0;
      for (int j = 0; j < n; j++) begin
        if (j == i) continue;
        if (actual_v[j] < lo) lo = actual_v[j];
        if (actual_v[j] > hi) hi = actual_v[j];
      end
      v = target_v[i];
      if (v < hi - sp) v = hi - sp;
      if (v > lo + sp) v = lo + sp;
      if (v == act) continue;
      if (!found || (rising && v < best_v) || (!rising && v > best_v)) begin
        found = 1'b1;
        best_v = v;
        best_i = i;
      end
    end
    if (found) begin
      move_idx = best_i[IDX_W-1:0];
      move_v = best_v[VOLT_W-1:0];
    end
    return found;
  endfunction

  // one request through the sequencer, returns its reply
  function automatic rail_reply_t sequencer_step(input rail_request_t rq);
    rail_reply_t reply;
    int unsigned n;
    bit          active;
    longint      top, bottom, floor_v, sp;
    reply = '0;
    n = rails_active();
    active = rq.idx < n;
    sp = cfg_spread;
    reply.status = ST_DONE;
    case (rq.op)
      OP_PRESET: begin
        if (seq_busy) begin
          reply.status = ST_BUSY;
        end else if (active) begin
          actual_v[rq.idx] = rq.volt;
          desired_v[rq.idx] = rq.volt;
        end
      end
      OP_REQUEST: begin
        if (seq_busy) begin
          reply.status = ST_BUSY;
        end else if (active) begin
          rising = rq.volt > desired_v[rq.idx];
          desired_v[rq.idx] = rq.volt;
          // targets: desired, lifted to the highest desired minus the spread
          top = 0;
          bottom = VOLT_MAX;
          for (int i = 0; i < n; i++) begin
            if (desired_v[i] > top) top = desired_v[i];
            if (desired_v[i] < bottom) bottom = desired_v[i];
          end
          floor_v = top - sp;
          if (floor_v < bottom) floor_v = bottom;
          for (int i = 0; i < n; i++) begin
            target_v[i] = (longint'(desired_v[i]) > floor_v) ? desired_v[i] :
                          floor_v[VOLT_W-1:0];
          end
          seq_busy = next_move();
          reply.status = seq_busy ? ST_MOVE : ST_DONE;
        end
      end
      OP_ACK: begin
        if (!seq_busy) begin
          reply.status = ST_STRAY;
        end else if (rq.err) begin
          seq_busy = 1'b0;
          reply.status = ST_ABORT;
        end else begin
          actual_v[move_idx] = move_v;
          seq_busy = next_move();
          reply.status = seq_busy ? ST_MOVE : ST_DONE;
        end
      end
      default: reply.status = ST_STRAY;
    endcase
    if (reply.status == ST_MOVE) begin
      reply.mrail = move_idx;
      reply.mvolt = move_v;
    end
    reply.rvolt = active ? actual_v[rq.idx] : '0;
    return reply;
  endfunction

  // idle length: mostly none, sometimes short, rarely long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // request accept and prediction
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      predicted_replies.push_back(sequencer_step(
        rail_request_t'({operation, rail_index, voltage, downstream_error})));
      offering = 1'b0;
      send_gap = pick_gap();
      accepted++;
    end
  end

  // request driver
  always @(negedge clk) begin
    if (!rst && !offering) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (request_backlog.size() > 0) begin
        next_rq = request_backlog.pop_front();
        operation <= next_rq.op;
        rail_index <= next_rq.idx;
        voltage <= next_rq.volt;
        downstream_error <= next_rq.err;
        in_valid <= 1'b1;
        offering = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // reply ready, with random gaps and one long hold-off
  always @(negedge clk) begin
    if (stall_request) begin
      hold_left = STALL_LONG;
      stall_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string field, input logic [VOLT_W-1:0] want,
                             input logic [VOLT_W-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // reply monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (predicted_replies.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: reply with no request outstanding, status %0d", $time, status);
      end else begin
        want_reply = predicted_replies.pop_front();
        check_field("status", want_reply.status, status);
        check_field("move_rail", want_reply.mrail, move_rail);
        check_field("move_voltage", want_reply.mvolt, move_voltage);
        check_field("rail_voltage", want_reply.rvolt, rail_voltage);
        status_seen[want_reply.status]++;
      end
      ready_gap = pick_gap();
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic wait_drained();
    while (request_backlog.size() != 0 || offering || predicted_replies.size() != 0)
      @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    if (idx == CFG_MAX_SPREAD)
      cfg_spread = data[SPREAD_W-1:0];
    else
      cfg_count = data[COUNT_W-1:0];
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                               input logic [VOLT_W-1:0] volt, input logic err);
    request_backlog.push_back(rail_request_t'({op, idx, volt, err}));
    if (op == OP_ACK || (op != OP_NONE && idx < rails_active()))
      real_requests++;
  endtask

  // voltage scattered around the current base, clamped to the field range
  function automatic logic [VOLT_W-1:0] near_base();
    longint span, v;
    span = cfg_spread;
    if (span > 400000) span = 400000;
    if (span < 1000) span = 1000;
    span = span * 3;
    v = base_v + longint'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > VOLT_MAX) v = VOLT_MAX;
    return v[VOLT_W-1:0];
  endfunction

  // any operation, any rail, any content
  task automatic queue_noise();
    logic [OP_W-1:0]   op;
    logic [VOLT_W-1:0] volt;
    op = $urandom_range(0, 3);
    volt = (op == OP_PRESET || op == OP_REQUEST) ? near_base() : VOLT_W'($urandom());
    queue_request(op, $urandom_range(0, RAILS - 1), volt, $urandom_range(0, 1));
  endtask

  // call only when drained and idle
  task automatic preset_rails(input bit every_rail);
    int unsigned n;
    n = rails_active();
    for (int i = 0; i < n; i++)
      if (every_rail || $urandom_range(0, 1))
        queue_request(OP_PRESET, i, near_base(), $urandom_range(0, 1));
  endtask

  // acknowledge moves in bursts until the sequence ends, abort if it drags on
  task automatic settle_sequence();
    int unsigned rounds;
    rounds = 0;
    wait_drained();
    while (seq_busy) begin
      rounds++;
      if (rounds > 8) begin
        queue_request(OP_ACK, $urandom_range(0, RAILS - 1), VOLT_W'($urandom()), 1'b1);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 19) == 0) queue_noise();
          queue_request(OP_ACK, $urandom_range(0, RAILS - 1), VOLT_W'($urandom()),
                        $urandom_range(0, 49) == 0);
        end
      end
      wait_drained();
    end
  endtask

  task automatic run_sequence();
    int unsigned       n;
    logic [IDX_W-1:0]  idx;
    logic [VOLT_W-1:0] volt;
    if ($urandom_range(0, 9) != 0) wait_drained();
    n = rails_active();
    idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, RAILS - 1) : $urandom_range(0, n - 1);
    volt = ($urandom_range(0, 9) == 0) ? desired_v[idx] : near_base();
    queue_request(OP_REQUEST, idx, volt, $urandom_range(0, 1));
    settle_sequence();
  endtask

  // stimulus
  initial begin
    logic [SPREAD_W-1:0]   spread_set [PHASES];
    logic [CFG_DATA_W-1:0] count_set [PHASES];
    int unsigned           r;

    spread_set = '{SPREAD_RESET, 24'd0, 24'd2500, VOLT_MAX,
                   SPREAD_W'($urandom_range(1000, 300000))};
    count_set = '{24'h000004, 24'h5A5A53, 24'h000000, 24'h000007, CFG_DATA_W'($urandom())};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // bring-up: all four rails preset so nothing reads an unwritten rail
    cfg_write(CFG_RAIL_COUNT, 24'hFFFFFC);
    queue_request(OP_PRESET, 0, 24'd1000000, 1'b0);
    queue_request(OP_PRESET, 1, 24'd1050000, 1'b1);
    queue_request(OP_PRESET, 2, 24'd1020000, 1'b0);
    queue_request(OP_PRESET, 3, 24'd1080000, 1'b0);
    // unused operation, then acknowledge with nothing pending
    queue_request(OP_NONE, 2, 24'h0F0F0F, 1'b1);
    queue_request(OP_ACK, 1, 24'd0, 1'b0);
    // rising request, refusals while busy, one good ack, then an ack with an error
    queue_request(OP_REQUEST, 0, 24'd1200000, 1'b0);
    queue_request(OP_REQUEST, 1, 24'd900000, 1'b0);
    queue_request(OP_PRESET, 2, 24'd500000, 1'b0);
    queue_request(OP_ACK, 0, 24'd0, 1'b0);
    queue_request(OP_ACK, 3, 24'd0, 1'b1);
    wait_drained();
    // request equal to the current desired voltage counts as falling
    queue_request(OP_REQUEST, 3, desired_v[3], 1'b0);
    settle_sequence();
    // two rails: rails two and three are ignored
    cfg_write(CFG_RAIL_COUNT, 24'hABCDE2);
    queue_request(OP_PRESET, 3, 24'd7, 1'b0);
    queue_request(OP_REQUEST, 2, 24'd7, 1'b0);
    wait_drained();
    // full-scale spread and voltage extremes
    cfg_write(CFG_MAX_SPREAD, VOLT_MAX);
    queue_request(OP_PRESET, 0, 24'd0, 1'b0);
    queue_request(OP_PRESET, 1, VOLT_MAX, 1'b0);
    queue_request(OP_REQUEST, 0, VOLT_MAX, 1'b0);
    settle_sequence();

    // random phases, one register setting each
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      cfg_write(CFG_MAX_SPREAD, spread_set[phase]);
      cfg_write(CFG_RAIL_COUNT, count_set[phase]);
      case (phase)
        1: base_v = 0;
        3: base_v = VOLT_MAX;
        default: base_v = $urandom_range(0, VOLT_MAX);
      endcase
      steady_flow = (phase == 3);
      if (seq_busy) begin
        queue_request(OP_ACK, 0, 24'd0, 1'b1);
        wait_drained();
      end
      preset_rails(1'b1);
      // receiver holds off while the sender keeps pushing
      if (phase == 2) begin
        stall_request = 1'b1;
        repeat (10) queue_noise();
      end
      while (real_requests < 25 + (phase + 1) * 125) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          queue_noise();
        end else if (r < 22) begin
          wait_drained();
          if (!seq_busy) preset_rails(1'b0);
        end else begin
          run_sequence();
        end
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (predicted_replies.size() != 0) begin
      errors++;
      $display("%0t: %0d replies never arrived", $time, predicted_replies.size());
    end
    $display("covered %0d requests over %0d register writes, spread 0 to full scale, 2 to 4 rails",
             accepted, cfg_writes);
    $display("replies: %0d moves, %0d complete, %0d refused, %0d aborted, %0d stray",
             status_seen[ST_MOVE], status_seen[ST_DONE], status_seen[ST_BUSY],
             status_seen[ST_ABORT], status_seen[ST_STRAY]);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
